// ===== sv/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;
	localparam int PRIO_W = 16;
	localparam int OCC_W  = $clog2(DEPTH + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} spq_op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		spq_op_t             opcode;
		logic [ITEM_W-1:0]   new_item;
		logic [PRIO_W-1:0]   new_priority;
	} spq_req_t;

	typedef struct packed {
		logic [ITEM_W-1:0]   out_item;
		logic [PRIO_W-1:0]   out_priority;
		spq_status_t         status;
		logic                now_empty;
		logic [OCC_W-1:0]    occupancy;
	} spq_rsp_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} spq_state_t;

	typedef struct packed {
		logic execute;
	} spq_cmd_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue, DEPTH entries of a 32-bit item and a 16-bit priority.
// Request channel (req_valid/req_ready/req): opcode insert or remove, item, priority.
// Response channel (rsp_valid/rsp_ready/rsp): one response per request, in order,
// with the removed head item and priority, status, empty flag and occupancy.
// Smallest priority leaves first; among equal priorities the newest leaves first.
// Insert on a full queue is dropped (status full); remove on empty reports empty.
// Latency: the response is valid the cycle after the request is accepted.
// The controller takes a new request only after the previous response has
// been taken, so a stalled receiver holds the response stable and keeps
// req_ready low.
// All entries compare against the new priority in parallel and shift together,
// so latency does not depend on DEPTH or occupancy.
// Reset (arst_n low) empties the queue; entry contents are not cleared and are
// never read beyond the occupancy count.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Top level: handshake controller plus sorted cell datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_rsp_t rsp
);

	spq_cmd_t cmd;   // execute pulses on the accept edge

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Datapath updates the entries and loads the response register on execute.
	spq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: takes one request, holds its response until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_cmd_t cmd
);

	spq_state_t state_q;
	spq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.execute = req_valid;
				if (req_valid) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Row of sorted entry cells with per-cell compare, shift and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_dp
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  spq_cmd_t cmd,
	input  spq_req_t req,
	output spq_rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ITEM_W-1:0] items_q [DEPTH];
	logic [PRIO_W-1:0] prios_q [DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	spq_rsp_t          rsp_q;

	logic [DEPTH-1:0]  ge;      // valid entry with priority >= new one
	logic              full;
	logic              empty;
	logic              ins;
	logic              rem;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign ins   = cmd.execute && (req.opcode == OP_INSERT) && !full;
	assign rem   = cmd.execute && (req.opcode == OP_REMOVE) && !empty;

	always_comb begin
		cnt_d = cnt_q;
		if (ins) begin
			cnt_d = cnt_q + 1'b1;
		end else if (rem) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	// Each cell looks at itself and its two neighbors only.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic shift_in;   // neighbor below moves up on insert
		logic at_end;

		assign ge[i]  = (CNT_W'(i) < cnt_q) && (req.new_priority <= prios_q[i]);
		assign at_end = (CNT_W'(i) == cnt_q);

		if (i == 0) begin : g_head
			assign shift_in = 1'b0;
		end else begin : g_body
			assign shift_in = ge[i-1];
		end

		always_ff @(posedge clk) begin
			if (ins) begin
				if (shift_in) begin
					items_q[i] <= items_q[(i == 0) ? 0 : i-1];
					prios_q[i] <= prios_q[(i == 0) ? 0 : i-1];
				end else if (ge[i] || at_end) begin
					items_q[i] <= req.new_item;
					prios_q[i] <= req.new_priority;
				end
			end else if (rem && (i < DEPTH - 1)) begin
				items_q[i] <= items_q[(i < DEPTH - 1) ? i+1 : i];
				prios_q[i] <= prios_q[(i < DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp_q.out_item     <= rem ? items_q[0] : '0;
			rsp_q.out_priority <= rem ? prios_q[0] : '0;
			if (req.opcode == OP_INSERT) begin
				rsp_q.status <= full ? ST_FULL : ST_DONE;
			end else begin
				rsp_q.status <= empty ? ST_EMPTY : ST_DONE;
			end
			rsp_q.now_empty <= (cnt_d == '0);
			rsp_q.occupancy <= OCC_W'(cnt_d);
		end
	end

	assign rsp = rsp_q;

	`SPQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`SPQ_ASSERT_NOW(a_head_sorted, clk, arst_n, cnt_q >= CNT_W'(2), prios_q[0] <= prios_q[1])
	`SPQ_ASSERT_NEXT(a_ins_grows, clk, arst_n, ins, cnt_q == $past(cnt_q) + 1'b1)

endmodule
